[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property that must hold at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

[src/vfls_pkg.sv]
// ----------------------------------------------------------------------------
// vfls_pkg
// Types and constants for the framebuffer line scanout block.
// ----------------------------------------------------------------------------
package vfls_pkg;

	// framebuffer geometry
	localparam int WIDTH  = 20;
	localparam int HEIGHT = 30;
	localparam int DEPTH  = WIDTH * HEIGHT;

	// field widths
	localparam int COLOR_W = 8;
	localparam int COL_W   = 5;
	localparam int ROW_W   = 5;
	localparam int LINE_W  = 10;
	localparam int SHIFT_W = 3;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 10;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int BROW_W  = $clog2(HEIGHT);

	localparam logic [COLOR_W-1:0] BLACK = '0;

	// opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_TOTAL_LINES = 2'd0;
	localparam logic [CIDX_W-1:0] REG_FIRST_LINE  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_END_LINE    = 2'd2;
	localparam logic [CIDX_W-1:0] REG_ROW_SHIFT   = 2'd3;

	// register reset values
	localparam logic [LINE_W-1:0]  RST_TOTAL_LINES = 10'd525;
	localparam logic [LINE_W-1:0]  RST_FIRST_LINE  = 10'd35;
	localparam logic [LINE_W-1:0]  RST_END_LINE    = 10'd515;
	localparam logic [SHIFT_W-1:0] RST_ROW_SHIFT   = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_LAST
	} vfls_state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_step;
		logic do_write;
		logic do_tick;
		logic eval;
		logic issue_pixel;
		logic issue_last;
	} vfls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic scan_ok;
		logic col_last;
		logic advance;
	} vfls_sts_t;

endpackage

[src/vfls_ifs.sv]
// ----------------------------------------------------------------------------
// vfls_ifs
// Channel interfaces: input items, pixel results and register writes.
// ----------------------------------------------------------------------------
interface vfls_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [4:0] write_row;
	logic [4:0] write_column;
	logic [7:0] write_color;

	modport source (output valid, opcode, write_row, write_column, write_color, input ready);
	modport sink   (input valid, opcode, write_row, write_column, write_color, output ready);
endinterface

interface vfls_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_color;
	logic [4:0] pixel_column;
	logic [9:0] line_number;
	logic       frame_start;
	logic       in_active;
	logic       is_last;

	modport source (output valid, pixel_color, pixel_column, line_number, frame_start,
		in_active, is_last, input ready);
	modport sink   (input valid, pixel_color, pixel_column, line_number, frame_start,
		in_active, is_last, output ready);
endinterface

interface vfls_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[src/vfls_ctrl.sv]
// ----------------------------------------------------------------------------
// vfls_ctrl
// Sequencer: clearing pass, item intake, line evaluation and row scan.
// ----------------------------------------------------------------------------
module vfls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_opcode,
	output logic                in_ready,
	input  vfls_pkg::vfls_sts_t sts,
	output vfls_pkg::vfls_cmd_t cmd
);
	import vfls_pkg::*;

	vfls_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == OP_WRITE) begin
						cmd.do_write = 1'b1;
					end else begin
						cmd.do_tick = 1'b1;
						state_d     = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.scan_ok) begin
					state_d = ST_LAST;
				end else if (sts.advance) begin
					cmd.issue_pixel = 1'b1;
					if (sts.col_last) begin
						state_d = ST_LAST;
					end
				end
			end
			ST_LAST: begin
				if (sts.advance) begin
					cmd.issue_last = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

[src/vfls_dp.sv]
// ----------------------------------------------------------------------------
// vfls_dp
// Datapath: registers, line counter, frame store, read stage and output
// register.
// ----------------------------------------------------------------------------
module vfls_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vfls_pkg::vfls_cmd_t            cmd,
	output vfls_pkg::vfls_sts_t            sts,
	// register writes
	input  logic                           cfg_valid,
	input  logic [vfls_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [vfls_pkg::CDAT_W-1:0]    cfg_data,
	// write item fields
	input  logic [vfls_pkg::ROW_W-1:0]     write_row,
	input  logic [vfls_pkg::COL_W-1:0]     write_column,
	input  logic [vfls_pkg::COLOR_W-1:0]   write_color,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [vfls_pkg::COLOR_W-1:0]   pixel_color,
	output logic [vfls_pkg::COL_W-1:0]     pixel_column,
	output logic [vfls_pkg::LINE_W-1:0]    line_number,
	output logic                           frame_start,
	output logic                           in_active,
	output logic                           is_last
);
	import vfls_pkg::*;

	// configuration
	logic [LINE_W-1:0]  total_q, first_q, end_q;
	logic [SHIFT_W-1:0] shift_q;

	// line state
	logic [LINE_W-1:0]  line_q;
	logic               frame_q;
	logic               active_q;
	logic               scan_ok_q;
	logic [ADDR_W-1:0]  base_q;
	logic [COL_W-1:0]   col_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	// frame store
	logic [COLOR_W-1:0] mem [0:DEPTH-1];
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr, wr_addr, rd_addr;
	logic [COLOR_W-1:0] mem_wdata;
	logic               wr_in_range;

	// read stage
	logic               valid_s1;
	logic [COLOR_W-1:0] data_s1;
	logic [COL_W-1:0]   col_s1;
	logic               last_s1;
	logic [LINE_W-1:0]  line_s1;
	logic               frame_s1;
	logic               active_s1;

	// output register
	logic               out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic [COL_W-1:0]   column_q;
	logic [LINE_W-1:0]  line_out_q;
	logic               frame_out_q;
	logic               active_out_q;
	logic               last_out_q;

	logic               advance;
	logic [LINE_W:0]    line_inc;
	logic [LINE_W-1:0]  line_off, row_full;
	logic               eval_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= RST_TOTAL_LINES;
			first_q <= RST_FIRST_LINE;
			end_q   <= RST_END_LINE;
			shift_q <= RST_ROW_SHIFT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOTAL_LINES: total_q <= cfg_data;
				REG_FIRST_LINE:  first_q <= cfg_data;
				REG_END_LINE:    end_q   <= cfg_data;
				REG_ROW_SHIFT:   shift_q <= cfg_data[SHIFT_W-1:0];
				default:         ;
			endcase
		end
	end

	// line counter: compare at one extra bit so 1023 + 1 still wraps
	assign line_inc = {1'b0, line_q} + (LINE_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= '0;
			frame_q <= 1'b0;
		end else if (cmd.do_tick) begin
			if (line_inc >= {1'b0, total_q}) begin
				line_q  <= '0;
				frame_q <= 1'b1;
			end else begin
				line_q  <= line_inc[LINE_W-1:0];
				frame_q <= 1'b0;
			end
		end
	end

	// window and buffer row for the new line
	assign eval_active = (line_q >= first_q) && (line_q < end_q);
	assign line_off    = line_q - first_q;
	assign row_full    = line_off >> shift_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			active_q  <= eval_active;
			scan_ok_q <= eval_active && (row_full < LINE_W'(HEIGHT));
			base_q    <= ADDR_W'(ADDR_W'(row_full[BROW_W-1:0]) * ADDR_W'(WIDTH));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			col_q <= '0;
		end else if (cmd.issue_pixel) begin
			col_q <= col_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// store port: clearing pass or item write, read for the scan
	assign wr_in_range = (write_row < ROW_W'(HEIGHT)) && (write_column < COL_W'(WIDTH));
	assign wr_addr     = ADDR_W'(ADDR_W'(write_row) * ADDR_W'(WIDTH)) + ADDR_W'(write_column);
	assign mem_we      = cmd.clear_step || (cmd.do_write && wr_in_range);
	assign mem_waddr   = cmd.clear_step ? clr_addr_q : wr_addr;
	assign mem_wdata   = cmd.clear_step ? BLACK : write_color;
	assign rd_addr     = base_q + ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_pixel) begin
			data_s1 <= mem[rd_addr];
		end
	end

	// both stages move together whenever the output register frees up
	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd.issue_pixel || cmd.issue_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_pixel || cmd.issue_last) begin
			col_s1    <= cmd.issue_last ? COL_W'(WIDTH) : col_q;
			last_s1   <= cmd.issue_last;
			line_s1   <= line_q;
			frame_s1  <= frame_q;
			active_s1 <= active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			color_q      <= last_s1 ? BLACK : data_s1;
			column_q     <= col_s1;
			line_out_q   <= line_s1;
			frame_out_q  <= frame_s1;
			active_out_q <= active_s1;
			last_out_q   <= last_s1;
		end
	end

	assign sts.clear_done = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign sts.scan_ok    = scan_ok_q;
	assign sts.col_last   = (col_q == COL_W'(WIDTH - 1));
	assign sts.advance    = advance;

	assign out_valid    = out_valid_q;
	assign pixel_color  = color_q;
	assign pixel_column = column_q;
	assign line_number  = line_out_q;
	assign frame_start  = frame_out_q;
	assign in_active    = active_out_q;
	assign is_last      = last_out_q;

endmodule

[src/vga_framebuffer_line_scanout.sv]
// ----------------------------------------------------------------------------
// vga_framebuffer_line_scanout
// 20 x 30 byte framebuffer with one line of pixels, or only the closing black pixel, scanned out per tick.
// ----------------------------------------------------------------------------
// After reset the block clears the 600-entry frame store to black, one entry
// per cycle, and takes no item until the clearing is done (register writes are
// accepted throughout). A write item leaves the block ready for the next item.
// A line tick that lands on a buffer row holds off the next item through the
// counter update, the window evaluation, 20 store reads at one per cycle
// through the store read port while the pixel channel does not stall, and the
// trailing black pixel; when only the black pixel is sent, the steps are the
// counter update, the window evaluation, a scan state that sees that no row is
// scanned, and the black pixel. Stalls on the pixel channel lengthen both.
// Results leave through an output register behind a one-entry read stage.
module vga_framebuffer_line_scanout (
	input  logic         clk,
	input  logic         arst_n,
	vfls_item_if.sink    item,
	vfls_pix_if.source   pix,
	vfls_cfg_if.sink     cfg
);
	import vfls_pkg::*;

	vfls_cmd_t ctl_cmd;
	vfls_sts_t ctl_sts;

	assign cfg.ready = 1'b1;

	vfls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_opcode (item.opcode),
		.in_ready  (item.ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	vfls_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (ctl_sts),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.write_row    (item.write_row),
		.write_column (item.write_column),
		.write_color  (item.write_color),
		.out_valid    (pix.valid),
		.out_ready    (pix.ready),
		.pixel_color  (pix.pixel_color),
		.pixel_column (pix.pixel_column),
		.line_number  (pix.line_number),
		.frame_start  (pix.frame_start),
		.in_active    (pix.in_active),
		.is_last      (pix.is_last)
	);

endmodule

[src/vfls_checker.sv]
// ----------------------------------------------------------------------------
// vfls_checker
// Port-level checks on the pixel channel of the scanout block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vfls_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pix_valid,
	input logic                           pix_ready,
	input logic [vfls_pkg::COLOR_W-1:0]   pix_color,
	input logic [vfls_pkg::COL_W-1:0]     pix_column,
	input logic [vfls_pkg::LINE_W-1:0]    pix_line,
	input logic                           pix_frame,
	input logic                           pix_active,
	input logic                           pix_last
);
	import vfls_pkg::*;

	// a stalled transaction keeps its payload
	`ASSERT_CLK(a_pix_hold, pix_valid && !pix_ready |=> pix_valid && $stable(pix_color) && $stable(pix_column) && $stable(pix_last), "pixel transaction changed while stalled")

	// the closing pixel of a line is black and sits past the last column
	`ASSERT_CLK(a_last_black, pix_valid && pix_last |-> pix_color == BLACK && pix_column == COL_W'(WIDTH), "closing pixel not black at column WIDTH")

	// stored pixels only come from lines in the window, inside the row
	`ASSERT_CLK(a_stored_px, pix_valid && !pix_last |-> pix_active && pix_column < COL_W'(WIDTH), "stored pixel outside window or row")

	// a wrapped counter always restarts at line zero
	`ASSERT_NEVER(a_frame_line, pix_valid && pix_frame && pix_line != '0, "frame start on nonzero line")

endmodule

bind vga_framebuffer_line_scanout vfls_checker u_vfls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix.valid),
	.pix_ready  (pix.ready),
	.pix_color  (pix.pixel_color),
	.pix_column (pix.pixel_column),
	.pix_line   (pix.line_number),
	.pix_frame  (pix.frame_start),
	.pix_active (pix.in_active),
	.pix_last   (pix.is_last)
);
